// ----- rtl/core/scpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types and constants for the pair-difference counter.
// ----------------------------------------------------------------------------
package scpd_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CW        = AW + 1;
  localparam int BW        = AW + 2;
  localparam int VW        = 31;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          last_item;
  } in_t;

  typedef struct packed {
    logic [10:0] pair_count;
    logic        overflow;
  } out_t;

  function automatic logic [BW-1:0] min_b(input logic [BW-1:0] a, input logic [BW-1:0] b);
    min_b = (a < b) ? a : b;
  endfunction

endpackage

// ----- rtl/core/sort_and_count_pairs_with_difference_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_and_count_pairs_with_difference_core
// Collects a set of values, merge sorts it in RAM, counts difference pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready, in_data) carry one value each; the
//   request with last_item set closes the set. Values beyond MAX_ITEMS are
//   dropped and flagged as overflow. Loading takes one request per cycle.
//   After the closing request the block sorts with a bottom-up merge sort
//   between two RAMs (a read state and a write state per element per pass,
//   ceil(log2 n) passes), then runs a two-pointer scan of at most 2n steps,
//   each a read state and a compare state. The RAM read/compare loop sets
//   the throughput: in_ready is low from the closing request until the result
//   is taken. The result is held in out_data until out_ready is high.
//   pair_difference is written through cfg_we/cfg_wdata; the user must write
//   it only while idle, the block itself does not enforce it.
//   Reset (rst_n low, synchronous) empties the set, drops any pending
//   result and sets pair_difference to 1. No RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module sort_and_count_pairs_with_difference_core
  import scpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_t          out_data,
  input  logic          cfg_we,
  input  logic [VW-1:0] cfg_wdata
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;
  localparam logic [2:0] S_MWR  = 3'd2;
  localparam logic [2:0] S_CRD  = 3'd3;
  localparam logic [2:0] S_CEV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [VW-1:0] diff_r;
  logic [CW-1:0] n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_r, src_nxt;
  logic [BW-1:0] w_r, w_nxt, k_r, k_nxt, i_r, i_nxt, iend_r, iend_nxt;
  logic [BW-1:0] j_r, j_nxt, jend_r, jend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [VW-1:0] mem0 [MAX_ITEMS];
  logic [VW-1:0] mem1 [MAX_ITEMS];
  logic [VW-1:0] a0_r, b0_r, a1_r, b1_r;
  logic          we0, we1;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [VW-1:0] a, b;
  logic          take_left;
  logic [VW:0]   target;
  logic [BW-1:0] nb, w2;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign out_data.pair_count = cnt_r;
  assign out_data.overflow   = ovf_r;

  assign a  = src_r ? a1_r : a0_r;
  assign b  = src_r ? b1_r : b0_r;
  assign nb = {1'b0, n_r};
  assign w2 = {w_r[BW-2:0], 1'b0};
  assign take_left = (i_r < iend_r) && ((j_r >= jend_r) || (a <= b));
  assign target = {1'b0, a} + {1'b0, diff_r};

  always_ff @(posedge clk) begin
    if (we0) mem0[waddr] <= wdata;
    if (we1) mem1[waddr] <= wdata;
    a0_r <= mem0[i_r[AW-1:0]];
    b0_r <= mem0[j_r[AW-1:0]];
    a1_r <= mem1[i_r[AW-1:0]];
    b1_r <= mem1[j_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; ovf_nxt = ovf_r; src_nxt = src_r; w_nxt = w_r;
    k_nxt = k_r; i_nxt = i_r; iend_nxt = iend_r; j_nxt = j_r; jend_nxt = jend_r;
    cnt_nxt = cnt_r;
    we0 = 1'b0; we1 = 1'b0;
    waddr = k_r[AW-1:0];
    wdata = take_left ? a : b;
    unique case (state_r)
      S_LOAD: begin
        waddr = n_r[AW-1:0];
        wdata = in_data.value;
        if (in_valid) begin
          if (n_r < CW'(MAX_ITEMS)) begin
            we0 = 1'b1;
            n_nxt = n_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            src_nxt = 1'b0;
            w_nxt = BW'(1);
            k_nxt = '0;
            i_nxt = '0;
            iend_nxt = min_b(BW'(1), {1'b0, n_nxt});
            j_nxt = iend_nxt;
            jend_nxt = min_b(BW'(2), {1'b0, n_nxt});
            cnt_nxt = '0;
            state_nxt = (n_nxt > CW'(1)) ? S_MRD : S_CRD;
            if (n_nxt <= CW'(1)) begin
              i_nxt = '0;
              j_nxt = BW'(1);
            end
          end
        end
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: begin
        we0 = src_r;
        we1 = !src_r;
        if (take_left) i_nxt = i_r + 1'b1;
        else           j_nxt = j_r + 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = S_MRD;
        if (k_r + 1'b1 == nb) begin
          src_nxt = !src_r;
          w_nxt = w2;
          k_nxt = '0;
          i_nxt = '0;
          iend_nxt = min_b(w2, nb);
          j_nxt = min_b(w2, nb);
          jend_nxt = min_b({w2[BW-2:0], 1'b0}, nb);
          if (w2 >= nb) begin
            i_nxt = '0;
            j_nxt = BW'(1);
            state_nxt = S_CRD;
          end
        end else if (k_r + 1'b1 == jend_r) begin
          i_nxt = jend_r;
          iend_nxt = min_b(jend_r + w_r, nb);
          j_nxt = min_b(jend_r + w_r, nb);
          jend_nxt = min_b(jend_r + w2, nb);
        end
      end
      S_CRD: state_nxt = (i_r + 1'b1 >= nb) ? S_OUT : S_CEV;
      S_CEV: begin
        state_nxt = S_CRD;
        if ((j_r < nb) && ({1'b0, b} < target)) begin
          j_nxt = j_r + 1'b1;
        end else begin
          if ((j_r < nb) && ({1'b0, b} == target)) cnt_nxt = cnt_r + 1'b1;
          i_nxt = i_r + 1'b1;
          if (j_r < i_r + BW'(2)) j_nxt = i_r + BW'(2);
        end
      end
      S_OUT: begin
        if (out_ready) begin
          n_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      n_r     <= '0;
      ovf_r   <= 1'b0;
      diff_r  <= VW'(1);
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) diff_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt; w_r <= w_nxt; k_r <= k_nxt; i_r <= i_nxt; iend_r <= iend_nxt;
    j_r <= j_nxt; jend_r <= jend_nxt; cnt_r <= cnt_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_ITEMS)) else $error("item count exceeds store");

  a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> n_r == '0 && !ovf_r) else $error("set not cleared");

  a_cnt_le_n: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r <= n_r) else $error("pair count above set size");

endmodule
